[rtl/hhpi_pkg.sv]
package hhpi_pkg;

  // loop tick rate
  localparam int TICKS_PER_SECOND = 1000;

  // field widths
  localparam int YAW_W   = 16;
  localparam int SENS_W  = 12;
  localparam int GAIN_W  = 16;
  localparam int LIMIT_W = 9;
  localparam int ANG_W   = 32;
  localparam int ERR_W   = ANG_W + 1;
  localparam int ESUM_W  = 48;
  localparam int CMD_W   = 32;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GESTURE_TH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_TH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_LIM  = 3'd4;

  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = 16'd614;
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST = 16'd82;
  localparam logic [SENS_W-1:0]  GESTURE_TH_RST = 12'd250;
  localparam logic [SENS_W-1:0]  EXIT_TH_RST    = 12'd300;
  localparam logic [LIMIT_W-1:0] ANGLE_LIM_RST  = 9'd100;

  // degrees to angle accumulator units
  localparam int LIMIT_SCALE = 16 * TICKS_PER_SECOND;

  // error sum / ticks by reciprocal multiply, one correction step
  localparam int          RECIP_SH  = ESUM_W;
  localparam logic [47:0] RECIP     = 48'((64'd1 << RECIP_SH) / TICKS_PER_SECOND);
  localparam logic [47:0] TICKS_48  = 48'(TICKS_PER_SECOND);
  localparam int          QW        = ESUM_W - $clog2(TICKS_PER_SECOND);
  localparam int          DIV_LAT   = 5;

  // product widths of the gain stage
  localparam int P_W   = GAIN_W + 1 + ERR_W;
  localparam int IP_W  = GAIN_W + 1 + QW + 1;
  localparam int SUM_W = ((IP_W > P_W) ? IP_W : P_W) + 1;

  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_SEEN  = 2'd1,
    PH_CALIB = 2'd2,
    PH_HOLD  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    BEEP_NONE = 2'd0,
    BEEP_GO   = 2'd1,
    BEEP_EXIT = 2'd2
  } beep_t;

  // per-beat status carried alongside the divider
  typedef struct packed {
    phase_t                  phase;
    logic                    calib;
    logic                    drive;
    logic                    exit_req;
    beep_t                   beep;
    logic                    run;
    logic signed [ERR_W-1:0] err;
  } side_t;

  typedef struct packed {
    phase_t                  phase;
    logic                    calib;
    logic signed [CMD_W-1:0] cmd;
    logic                    drive;
    logic                    exit_req;
    beep_t                   beep;
  } res_t;

endpackage

[rtl/hhpi_in_if.sv]
interface hhpi_in_if;
  import hhpi_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [YAW_W-1:0] yaw_rate;
  logic [SENS_W-1:0]       front_right;
  logic [SENS_W-1:0]       front_left;
  logic                    calib_done;

  modport source (
    output valid, yaw_rate, front_right, front_left, calib_done,
    input  ready
  );

  modport sink (
    input  valid, yaw_rate, front_right, front_left, calib_done,
    output ready
  );
endinterface

[rtl/hhpi_out_if.sv]
interface hhpi_out_if;
  import hhpi_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              phase;
  logic                    calib_request;
  logic signed [CMD_W-1:0] turn_command;
  logic                    drive_enable;
  logic                    exit_request;
  logic [1:0]              beep_code;

  modport source (
    output valid, phase, calib_request, turn_command, drive_enable, exit_request,
           beep_code,
    input  ready
  );

  modport sink (
    input  valid, phase, calib_request, turn_command, drive_enable, exit_request,
           beep_code,
    output ready
  );
endinterface

[rtl/hhpi_div.sv]
module hhpi_div (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [hhpi_pkg::ESUM_W-1:0]   sum_i,
  output logic signed [hhpi_pkg::QW:0]         quo_o
);
  import hhpi_pkg::*;

  logic              neg1_r, neg2_r, neg3_r, neg4_r;
  logic [ESUM_W-1:0] mag1_r, mag2_r, mag3_r;
  logic [47:0]       pp_hh_r, pp_hl_r, pp_lh_r, pp_ll_r;
  logic [QW-1:0]     q0_r, q0_4_r;
  logic              ge_r;
  logic [95:0]       prod;
  logic [47:0]       rem;
  logic [QW-1:0]     qmag;

  // magnitude and sign, then four 24x24 partial products
  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r  <= sum_i[ESUM_W-1];
      mag1_r  <= sum_i[ESUM_W-1] ? ESUM_W'(-sum_i) : ESUM_W'(sum_i);
      neg2_r  <= neg1_r;
      mag2_r  <= mag1_r;
      pp_hh_r <= mag1_r[47:24] * RECIP[47:24];
      pp_hl_r <= mag1_r[47:24] * RECIP[23:0];
      pp_lh_r <= mag1_r[23:0] * RECIP[47:24];
      pp_ll_r <= mag1_r[23:0] * RECIP[23:0];
    end
  end

  // sum partials into the estimate, one low at most
  always_comb begin
    prod = {pp_hh_r, 48'd0} + {24'd0, pp_hl_r, 24'd0} + {24'd0, pp_lh_r, 24'd0}
         + {48'd0, pp_ll_r};
    rem  = mag3_r - (48'(q0_r) * TICKS_48);
    qmag = q0_4_r + QW'(ge_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg3_r <= neg2_r;
      mag3_r <= mag2_r;
      q0_r   <= prod[RECIP_SH+QW-1:RECIP_SH];
      // remainder check and fix-up
      neg4_r <= neg3_r;
      q0_4_r <= q0_r;
      ge_r   <= (rem >= TICKS_48);
      // apply sign, truncating toward zero
      quo_o  <= neg4_r ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    end
  end

endmodule

[rtl/heading_hold_pi_with_gesture_start.sv]
// Throughput: one beat per cycle while the output queue has room; the
// divide-by-tick-rate pipeline and the gain multiply stage set the depth,
// the state update is combinational from the input register.
// A two-entry output queue keeps input ready while a result waits.
// Reset (synchronous, rst_n low): phase flags, angle and error sums cleared,
// registers back to defaults, pipeline and queue emptied.
module heading_hold_pi_with_gesture_start (
  input  logic                                clk,
  input  logic                                rst_n,
  hhpi_in_if.sink                             in_ch,
  hhpi_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [hhpi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hhpi_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import hhpi_pkg::*;

  // configuration registers
  logic [GAIN_W-1:0]  prop_r, integ_r;
  logic [SENS_W-1:0]  gest_th_r, exit_th_r;
  logic [LIMIT_W-1:0] lim_deg_r;

  // input stage
  logic                    s0_valid_r;
  logic signed [YAW_W-1:0] s0_rate_r;
  logic [SENS_W-1:0]       s0_fr_r, s0_fl_r;
  logic                    s0_cdone_r;

  // controller state
  logic                     hand_seen_r, hand_gone_r, holding_r;
  logic signed [ANG_W-1:0]  angle_r;
  logic signed [ESUM_W-1:0] esum_r;
  logic                     hand_seen_nxt, hand_gone_nxt, holding_nxt;
  logic signed [ANG_W-1:0]  angle_nxt;
  logic signed [ESUM_W-1:0] esum_nxt;

  // update stage
  logic                     s1_valid_r;
  side_t                    s1_side_r;
  logic signed [ESUM_W-1:0] s1_esum_r;
  side_t                    side_nxt;

  // delay line matching the divider
  logic                     dvld_r [DIV_LAT];
  side_t                    dly_r  [DIV_LAT];
  logic signed [QW:0]       quo;

  // gain stage
  logic                     m_valid_r;
  side_t                    m_side_r;
  logic signed [P_W-1:0]    m_p_r;
  logic signed [IP_W-1:0]   m_i_r;

  // output queue
  res_t                     fifo_r [2];
  logic                     wr_ptr_r, rd_ptr_r;
  logic [1:0]               cnt_r;
  logic                     adv, push, pop;
  res_t                     res_nxt;

  logic signed [ANG_W:0]    ang_sum, ang_ext;
  logic [ANG_W:0]           ang_abs, lim;
  logic signed [ERR_W-1:0]  err;
  logic signed [ESUM_W:0]   es_sum;
  logic                     go, over, ex;
  logic signed [P_W-1:0]    p_adj, p_sh;
  logic signed [IP_W-1:0]   i_adj, i_sh;
  logic signed [SUM_W-1:0]  cmd_sum;
  logic [SUM_W-32:0]        cmd_hi;

  // pipeline moves whenever the queue has room
  assign adv         = (cnt_r != 2'd2);
  assign in_ch.ready = adv;
  assign push        = m_valid_r && adv;
  assign pop         = out_ch.valid && out_ch.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_r    <= PROP_GAIN_RST;
      integ_r   <= INTEG_GAIN_RST;
      gest_th_r <= GESTURE_TH_RST;
      exit_th_r <= EXIT_TH_RST;
      lim_deg_r <= ANGLE_LIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROP_GAIN:  prop_r    <= cfg_wdata;
        CFG_INTEG_GAIN: integ_r   <= cfg_wdata;
        CFG_GESTURE_TH: gest_th_r <= cfg_wdata[SENS_W-1:0];
        CFG_EXIT_TH:    exit_th_r <= cfg_wdata[SENS_W-1:0];
        CFG_ANGLE_LIM:  lim_deg_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_rate_r  <= in_ch.yaw_rate;
      s0_fr_r    <= in_ch.front_right;
      s0_fl_r    <= in_ch.front_left;
      s0_cdone_r <= in_ch.calib_done;
    end
  end

  // gesture sequencing, angle and error integration
  always_comb begin
    hand_seen_nxt = hand_seen_r;
    hand_gone_nxt = hand_gone_r;
    holding_nxt   = holding_r;
    angle_nxt     = angle_r;
    esum_nxt      = esum_r;
    go            = 1'b0;

    ang_sum = (ANG_W+1)'(angle_r) + (ANG_W+1)'(s0_rate_r);
    if (ang_sum[ANG_W] != ang_sum[ANG_W-1]) begin
      angle_nxt = ang_sum[ANG_W] ? {1'b1, {(ANG_W-1){1'b0}}} : {1'b0, {(ANG_W-1){1'b1}}};
    end else begin
      angle_nxt = ang_sum[ANG_W-1:0];
    end
    ang_ext = (ANG_W+1)'(angle_nxt);
    err     = -ang_ext;
    es_sum  = (ESUM_W+1)'(esum_r) + (ESUM_W+1)'(err);
    if (es_sum[ESUM_W] != es_sum[ESUM_W-1]) begin
      esum_nxt = es_sum[ESUM_W] ? {1'b1, {(ESUM_W-1){1'b0}}} : {1'b0, {(ESUM_W-1){1'b1}}};
    end else begin
      esum_nxt = es_sum[ESUM_W-1:0];
    end

    // angle limit and exit gesture
    ang_abs = ang_ext[ANG_W] ? (ANG_W+1)'(-ang_ext) : (ANG_W+1)'(ang_ext);
    lim     = (ANG_W+1)'(lim_deg_r) * (ANG_W+1)'(LIMIT_SCALE);
    over    = ang_abs > lim;
    ex      = (s0_fr_r > exit_th_r) && (s0_fl_r > exit_th_r);

    side_nxt = '0;
    side_nxt.err = err;
    if (holding_r) begin
      side_nxt.phase    = PH_HOLD;
      side_nxt.run      = 1'b1;
      side_nxt.drive    = !over;
      side_nxt.exit_req = over || ex;
      side_nxt.beep     = ex ? BEEP_EXIT : BEEP_NONE;
    end else begin
      angle_nxt     = angle_r;
      esum_nxt      = esum_r;
      hand_seen_nxt = hand_seen_r || (s0_fr_r > gest_th_r) || (s0_fl_r > gest_th_r);
      go            = !hand_gone_r && hand_seen_nxt &&
                      (s0_fr_r < gest_th_r) && (s0_fl_r < gest_th_r);
      hand_gone_nxt = hand_gone_r || go;
      holding_nxt   = hand_gone_nxt && s0_cdone_r;
      side_nxt.calib = hand_gone_nxt;
      side_nxt.beep  = go ? BEEP_GO : BEEP_NONE;
      if (holding_nxt) begin
        side_nxt.phase = PH_HOLD;
      end else if (hand_gone_nxt) begin
        side_nxt.phase = PH_CALIB;
      end else if (hand_seen_nxt) begin
        side_nxt.phase = PH_SEEN;
      end else begin
        side_nxt.phase = PH_WAIT;
      end
    end
  end

  // state and update stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hand_seen_r <= 1'b0;
      hand_gone_r <= 1'b0;
      holding_r   <= 1'b0;
      angle_r     <= '0;
      esum_r      <= '0;
      s1_valid_r  <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= s0_valid_r;
      if (s0_valid_r) begin
        hand_seen_r <= hand_seen_nxt;
        hand_gone_r <= hand_gone_nxt;
        holding_r   <= holding_nxt;
        angle_r     <= angle_nxt;
        esum_r      <= esum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side_r <= side_nxt;
      s1_esum_r <= esum_nxt;
    end
  end

  // error sum divided by the tick rate
  hhpi_div u_div (
    .clk   (clk),
    .en    (adv),
    .sum_i (s1_esum_r),
    .quo_o (quo)
  );

  // status delay line alongside the divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        dvld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      dvld_r[0] <= s1_valid_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        dvld_r[k] <= dvld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dly_r[0] <= s1_side_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        dly_r[k] <= dly_r[k-1];
      end
    end
  end

  // proportional and integral products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (adv) begin
      m_valid_r <= dvld_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_side_r <= dly_r[DIV_LAT-1];
      m_p_r    <= $signed({1'b0, prop_r}) * dly_r[DIV_LAT-1].err;
      m_i_r    <= $signed({1'b0, integ_r}) * quo;
    end
  end

  // scale by 1/4096 toward zero, add and saturate
  always_comb begin
    p_adj   = m_p_r + $signed({{(P_W-12){1'b0}}, {12{m_p_r[P_W-1]}}});
    i_adj   = m_i_r + $signed({{(IP_W-12){1'b0}}, {12{m_i_r[IP_W-1]}}});
    p_sh    = p_adj >>> 12;
    i_sh    = i_adj >>> 12;
    cmd_sum = SUM_W'(p_sh) + SUM_W'(i_sh);
    cmd_hi  = cmd_sum[SUM_W-1:31];

    res_nxt.phase    = m_side_r.phase;
    res_nxt.calib    = m_side_r.calib;
    res_nxt.drive    = m_side_r.drive;
    res_nxt.exit_req = m_side_r.exit_req;
    res_nxt.beep     = m_side_r.beep;
    if (!m_side_r.run) begin
      res_nxt.cmd = '0;
    end else if (cmd_hi == '0 || cmd_hi == '1) begin
      res_nxt.cmd = cmd_sum[CMD_W-1:0];
    end else begin
      res_nxt.cmd = cmd_sum[SUM_W-1] ? {1'b1, {(CMD_W-1){1'b0}}} : {1'b0, {(CMD_W-1){1'b1}}};
    end
  end

  // two-entry output queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= res_nxt;
    end
  end

  assign out_ch.valid         = (cnt_r != 2'd0);
  assign out_ch.phase         = fifo_r[rd_ptr_r].phase;
  assign out_ch.calib_request = fifo_r[rd_ptr_r].calib;
  assign out_ch.turn_command  = fifo_r[rd_ptr_r].cmd;
  assign out_ch.drive_enable  = fifo_r[rd_ptr_r].drive;
  assign out_ch.exit_request  = fifo_r[rd_ptr_r].exit_req;
  assign out_ch.beep_code     = fifo_r[rd_ptr_r].beep;

  // holding is left only through reset
  assert property (@(posedge clk) disable iff (!rst_n) holding_r |=> holding_r)
    else $error("holding phase left without reset");

  // gesture flags advance in order
  assert property (@(posedge clk) disable iff (!rst_n)
    (hand_gone_r |-> hand_seen_r) and (holding_r |-> hand_gone_r))
    else $error("gesture flags out of order");

  // drive only while holding heading
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.drive_enable |-> out_ch.phase == PH_HOLD)
    else $error("drive enabled outside holding phase");

  // exit beep always comes with an exit request
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.beep_code == BEEP_EXIT |-> out_ch.exit_request)
    else $error("exit beep without exit request");

  // queue never overfills
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("output queue overflow");

endmodule

[test/tb_heading_hold_pi_with_gesture_start.sv]
module tb_heading_hold_pi_with_gesture_start;
  import hhpi_pkg::*;

  localparam int RESULT_LAG = 8;

  // saturation bounds of the angle and the integrated error
  localparam longint ANG_HI  = 64'sd2147483647;
  localparam longint ANG_LO  = -64'sd2147483648;
  localparam longint IERR_HI = 64'sd140737488355327;
  localparam longint IERR_LO = -64'sd140737488355328;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
  typedef enum int {RUN_QUIET, RUN_PUSH, RUN_NOISE} yaw_run_t;

  typedef struct {
    logic signed [YAW_W-1:0] yaw;
    logic [SENS_W-1:0]       fr;
    logic [SENS_W-1:0]       fl;
    logic                    cdone;
  } tick_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hhpi_in_if  in_bus ();
  hhpi_out_if out_bus ();

  heading_hold_pi_with_gesture_start dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor copy of registers and controller state
  logic [GAIN_W-1:0]  kp_reg;
  logic [GAIN_W-1:0]  ki_reg;
  logic [SENS_W-1:0]  gesture_lvl;
  logic [SENS_W-1:0]  exit_lvl;
  logic [LIMIT_W-1:0] limit_deg;
  longint heading;
  longint heading_err_int;
  bit     p_armed;
  bit     p_cleared;
  bit     p_locked;

  tick_t  ticks_to_send[$];
  res_t   tick_results_q[$];
  longint plan_angle;
  int     send_gap_pct;
  int     stall_pct;
  int     ticks_sent;
  int     results_checked;
  int     fail_count;
  bit     in_beat;

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // one control tick: update state, return the expected result beat
  function automatic res_t predict_tick(input tick_t t);
    res_t   r;
    longint rate, err, pterm, iterm, lim;
    r = '0;
    r.phase = PH_WAIT;
    r.beep = BEEP_NONE;
    if (!p_locked) begin
      if (t.fr > gesture_lvl || t.fl > gesture_lvl) p_armed = 1'b1;
      if (!p_cleared && p_armed && t.fr < gesture_lvl && t.fl < gesture_lvl) begin
        p_cleared = 1'b1;
        r.beep = BEEP_GO;
      end
      if (p_cleared) begin
        r.calib = 1'b1;
        if (t.cdone) p_locked = 1'b1;
      end
    end else begin
      rate = longint'(t.yaw);
      heading = clip(heading + rate, ANG_LO, ANG_HI);
      err = -heading;
      heading_err_int = clip(heading_err_int + err, IERR_LO, IERR_HI);
      pterm = (longint'(kp_reg) * err) / 4096;
      iterm = ((heading_err_int / TICKS_PER_SECOND) * longint'(ki_reg)) / 4096;
      r.cmd = CMD_W'(clip(pterm + iterm, ANG_LO, ANG_HI));
      r.drive = 1'b1;
      lim = longint'(limit_deg) * LIMIT_SCALE;
      if (heading > lim || heading < -lim) begin
        r.drive = 1'b0;
        r.exit_req = 1'b1;
      end
      if (t.fr > exit_lvl && t.fl > exit_lvl) begin
        r.exit_req = 1'b1;
        r.beep = BEEP_EXIT;
      end
    end
    if (p_locked) r.phase = PH_HOLD;
    else if (p_cleared) r.phase = PH_CALIB;
    else if (p_armed) r.phase = PH_SEEN;
    return r;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #20000000;
    $display("heading_hold_pi_with_gesture_start test failed");
    $finish;
  end

  // input driver, holds each beat until taken
  always @(negedge clk) begin
    tick_t nxt;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      out_bus.ready <= 1'b0;
    end else begin
      if (!in_bus.valid || in_beat) begin
        if (ticks_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          nxt = ticks_to_send.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.yaw_rate <= nxt.yaw;
          in_bus.front_right <= nxt.fr;
          in_bus.front_left <= nxt.fl;
          in_bus.calib_done <= nxt.cdone;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
      out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor: predict on input beats, check output beats
  always @(posedge clk) begin
    tick_t cur;
    res_t  want, got;
    bit    bad;
    in_beat <= rst_n && in_bus.valid && in_bus.ready;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        cur.yaw = in_bus.yaw_rate;
        cur.fr = in_bus.front_right;
        cur.fl = in_bus.front_left;
        cur.cdone = in_bus.calib_done;
        tick_results_q.push_back(predict_tick(cur));
      end
      if (out_bus.valid === 1'b1 && out_bus.ready) begin
        got.phase = phase_t'(out_bus.phase);
        got.calib = out_bus.calib_request;
        got.cmd = out_bus.turn_command;
        got.drive = out_bus.drive_enable;
        got.exit_req = out_bus.exit_request;
        got.beep = beep_t'(out_bus.beep_code);
        results_checked++;
        if (tick_results_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result beat %0d arrived with nothing outstanding", results_checked);
        end else begin
          want = tick_results_q.pop_front();
          bad = (got.phase !== want.phase) || (got.calib !== want.calib) ||
                (got.cmd !== want.cmd) || (got.drive !== want.drive) ||
                (got.exit_req !== want.exit_req) || (got.beep !== want.beep);
          if (bad) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("beat %0d expected: phase %0d calib %0b cmd %0d drive %0b exit %0b beep %0d",
                       results_checked, want.phase, want.calib, $signed(want.cmd),
                       want.drive, want.exit_req, want.beep);
              $display("beat %0d actual:   phase %0d calib %0b cmd %0d drive %0b exit %0b beep %0d",
                       results_checked, got.phase, got.calib, $signed(got.cmd),
                       got.drive, got.exit_req, got.beep);
            end
          end
        end
      end
    end
  end

  task automatic send_tick(input int yaw_v, input int fr_v, input int fl_v, input bit cd);
    tick_t t;
    t.yaw = yaw_v[YAW_W-1:0];
    t.fr = fr_v[SENS_W-1:0];
    t.fl = fl_v[SENS_W-1:0];
    t.cdone = cd;
    plan_angle += longint'(t.yaw);
    ticks_to_send.push_back(t);
    ticks_sent++;
  endtask

  // wait until every queued beat is sent and every result is back
  task automatic settle();
    while (ticks_to_send.size() != 0 || in_bus.valid || tick_results_q.size() != 0)
      @(posedge clk);
    repeat (RESULT_LAG + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PROP_GAIN:  kp_reg = val[GAIN_W-1:0];
      CFG_INTEG_GAIN: ki_reg = val[GAIN_W-1:0];
      CFG_GESTURE_TH: gesture_lvl = val[SENS_W-1:0];
      CFG_EXIT_TH:    exit_lvl = val[SENS_W-1:0];
      CFG_ANGLE_LIM:  limit_deg = val[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_idle(input idle_mode_t m);
    case (m)
      IDLE_NONE: begin send_gap_pct = 0;  stall_pct = 0;  end
      IDLE_SEND: begin send_gap_pct = 56; stall_pct = 0;  end
      IDLE_RECV: begin send_gap_pct = 0;  stall_pct = 56; end
      default:   begin send_gap_pct = 26; stall_pct = 26; end
    endcase
  endtask

  // stimulus
  initial begin
    int       left, yv, pick, dir;
    longint   corr;
    yaw_run_t kind;
    bit       hands;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.yaw_rate = '0;
    in_bus.front_right = '0;
    in_bus.front_left = '0;
    in_bus.calib_done = 1'b0;
    out_bus.ready = 1'b0;
    kp_reg = PROP_GAIN_RST;
    ki_reg = INTEG_GAIN_RST;
    gesture_lvl = GESTURE_TH_RST;
    exit_lvl = EXIT_TH_RST;
    limit_deg = ANGLE_LIM_RST;
    heading = 0;
    heading_err_int = 0;
    p_armed = 1'b0;
    p_cleared = 1'b0;
    p_locked = 1'b0;
    plan_angle = 0;
    ticks_sent = 0;
    results_checked = 0;
    fail_count = 0;
    left = 0;
    kind = RUN_QUIET;
    dir = 1;
    hands = 1'b0;
    set_idle(IDLE_NONE);
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // threshold at max: nothing can arm, calib_done ignored while waiting
    write_reg(CFG_GESTURE_TH, 16'd4095);
    send_tick(0, 4095, 4095, 1'b1);
    send_tick(0, 0, 0, 1'b1);
    for (int n = 0; n < 10; n++)
      send_tick($urandom_range(0, 65535), $urandom_range(0, 4095), $urandom_range(0, 4095),
                1'($urandom_range(1)));
    settle();

    // threshold zero: any nonzero level arms, nothing can count as gone
    write_reg(CFG_GESTURE_TH, 16'd0);
    set_idle(IDLE_BOTH);
    send_tick(0, 0, 0, 1'b0);
    send_tick(0, 0, 1, 1'b1);
    send_tick(0, 0, 0, 1'b1);
    for (int n = 0; n < 20; n++)
      send_tick($urandom_range(0, 65535), $urandom_range(0, 4095), $urandom_range(0, 4095),
                1'($urandom_range(1)));
    settle();

    // default threshold: levels equal to it neither arm nor clear
    write_reg(CFG_GESTURE_TH, 16'(GESTURE_TH_RST));
    set_idle(IDLE_RECV);
    send_tick(0, 250, 250, 1'b1);
    send_tick(0, 249, 250, 1'b0);
    send_tick(0, 100, 0, 1'b0);
    for (int n = 0; n < 25; n++)
      send_tick($urandom_range(0, 65535), $urandom_range(0, 4095), $urandom_range(0, 4095),
                1'b0);
    // calibration done: enters holding, loop starts next tick
    send_tick(32767, 0, 0, 1'b1);
    settle();

    // holding, default registers
    set_idle(IDLE_NONE);
    plan_angle = 0;
    send_tick(0, 0, 0, 1'b0);
    send_tick(32767, 300, 300, 1'b1);
    send_tick(-32768, 301, 301, 1'b0);
    send_tick(1, 4095, 0, 1'b0);
    settle();

    // zero angle limit: any nonzero angle cuts drive, also with exit gesture
    write_reg(CFG_ANGLE_LIM, 16'd0);
    send_tick(0, 0, 0, 1'b0);
    send_tick(5, 4095, 4095, 1'b0);
    send_tick(-5, 0, 0, 1'b1);
    send_tick(-32768, 0, 4095, 1'b0);
    send_tick(32768 - 1, 0, 0, 1'b0);

    // random holding runs under four register settings and idle patterns
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(CFG_PROP_GAIN, 16'hFFFF);
          write_reg(CFG_INTEG_GAIN, 16'hFFFF);
          write_reg(CFG_GESTURE_TH, 16'd4095);
          write_reg(CFG_EXIT_TH, 16'd0);
          write_reg(CFG_ANGLE_LIM, 16'd0);
          set_idle(IDLE_NONE);
        end
        1: begin
          write_reg(CFG_PROP_GAIN, 16'd0);
          write_reg(CFG_INTEG_GAIN, 16'd0);
          write_reg(CFG_EXIT_TH, 16'd4095);
          write_reg(CFG_ANGLE_LIM, 16'd511);
          set_idle(IDLE_SEND);
        end
        2: begin
          write_reg(CFG_PROP_GAIN, 16'($urandom_range(0, 65535)));
          write_reg(CFG_INTEG_GAIN, 16'($urandom_range(0, 65535)));
          write_reg(CFG_GESTURE_TH, 16'($urandom_range(0, 65535)));
          write_reg(CFG_EXIT_TH, 16'($urandom_range(0, 65535)));
          write_reg(CFG_ANGLE_LIM, 16'($urandom_range(0, 65535)));
          set_idle(IDLE_RECV);
        end
        default: begin
          write_reg(CFG_PROP_GAIN, PROP_GAIN_RST);
          write_reg(CFG_INTEG_GAIN, INTEG_GAIN_RST);
          write_reg(CFG_GESTURE_TH, 16'($urandom_range(0, 4095)));
          write_reg(CFG_EXIT_TH, 16'(EXIT_TH_RST));
          write_reg(CFG_ANGLE_LIM, 16'(ANGLE_LIM_RST));
          set_idle(IDLE_BOTH);
        end
      endcase
      for (int n = 0; n < 170; n++) begin
        // new run: quiet hold, a push toward the limit, or raw noise
        if (left == 0) begin
          left = $urandom_range(4, 40);
          pick = $urandom_range(99);
          kind = (pick < 55) ? RUN_QUIET : (pick < 75) ? RUN_PUSH : RUN_NOISE;
          dir = $urandom_range(1) ? 1 : -1;
          hands = ($urandom_range(99) < 20);
        end
        left--;
        case (kind)
          RUN_QUIET: begin
            corr = clip(plan_angle / 32, -30000, 30000);
            yv = int'($urandom_range(0, 2000)) - 1000 - int'(corr);
          end
          RUN_PUSH: yv = dir * int'($urandom_range(20000, 32767));
          default:  yv = int'($urandom_range(0, 65535)) - 32768;
        endcase
        if (hands)
          send_tick(yv, $urandom_range(2048, 4095), $urandom_range(2048, 4095),
                    1'($urandom_range(1)));
        else
          send_tick(yv,
                    $urandom_range(1) ? $urandom_range(0, 4095) : $urandom_range(0, 400),
                    $urandom_range(1) ? $urandom_range(0, 4095) : $urandom_range(0, 400),
                    1'($urandom_range(1)));
      end
    end
    settle();

    if (tick_results_q.size() != 0) fail_count++;
    $display("%0d ticks sent, %0d result beats checked, %0d failures",
             ticks_sent, results_checked, fail_count);
    $display("gesture arm and clear, calibration handoff, exit and limit cases, gain extremes");
    if (fail_count == 0) begin
      $display("heading_hold_pi_with_gesture_start test passed");
    end else begin
      $display("heading_hold_pi_with_gesture_start test failed");
    end
    $finish;
  end

endmodule
